// ----- src/tffp_pkg.sv -----
// Package for the tab-separated frame parser: word layouts, control byte
// codes and result kinds. No dependencies; imported by the parser and its testbench.

package tffp_pkg;

  // Control bytes of the serial link
  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_SP  = 8'h20;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_PLUS  = 8'h2B;
  localparam logic [7:0] BYTE_MINUS = 8'h2D;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  // Shortest legal frame, STX through ETX
  localparam int unsigned MIN_FRAME_LEN = 7;

  // Number of decimal fields in a frame
  localparam int unsigned NUM_FIELDS = 4;

  // Magnitude cap for the field accumulators
  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  // Outstanding request codes
  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_SET  = 2'd1,
    REQ_GET  = 2'd2,
    REQ_RSVD = 2'd3
  } request_t;

  // Result classification
  typedef enum logic [2:0] {
    KIND_ACK       = 3'd0,
    KIND_NAK       = 3'd1,
    KIND_DATA      = 3'd2,
    KIND_FORMAT    = 3'd3,
    KIND_MISSING   = 3'd4
  } frame_kind_t;

  // Per-field parse phase, one-hot
  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_NUM  = 3'b010,
    PH_DONE = 3'b100
  } field_phase_t;

  // Input word
  typedef struct packed {
    logic [7:0] rx_byte;
    logic [1:0] pending_request;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic [2:0]         frame_kind;
    logic               request_done;
    logic               request_failed;
    logic               reply_ack;
    logic signed [31:0] command_code;
    logic signed [31:0] property_code;
    logic signed [31:0] property_value;
    logic signed [31:0] frame_check;
  } out_item_t;

endpackage

// ----- src/tffp_stream_if.sv -----
// Valid/ready stream channel carrying one word of a given payload type.
// Depends on nothing; payload types come from tffp_pkg at instantiation.

interface tffp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/tab_field_frame_parser.sv -----
// Tab-separated frame parser top level: input register, per-byte parse
// logic and result register. Depends on tffp_pkg and tffp_stream_if.
//
// Channel  Dir  Word        Accepted when
// rx       in   in_item_t   rx.valid && rx.ready
// result   out  out_item_t  result.valid && result.ready
//
// A byte accepted into the input register is parsed from there: the field accumulator
// (shift-add by ten) updates the parser state and, for a closing ETX, loads
// the result register, from which the result is offered. A
// byte can be taken every cycle; any byte waits in the input register while
// the result register is full and not taken. Reset (rst, synchronous)
// closes any open frame and empties both registers.

module tab_field_frame_parser
  import tffp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic          clk,
  input  logic          rst,
  tffp_stream_if.sink   rx,
  tffp_stream_if.source result
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_SHORT = CNT_W'(MIN_FRAME_LEN - 1);

  // Signed result of a field: negate, or clamp a positive magnitude
  function automatic logic [31:0] field_result(input logic [31:0] mag, input logic neg);
    if (neg) begin
      return 32'd0 - mag;
    end
    return mag[31] ? POS_MAX : mag;
  endfunction

  // Input register
  logic       in_valid;
  in_item_t   in_word;

  // Parser state
  logic               in_frame, in_frame_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [7:0]         second_byte, second_byte_next;
  logic [1:0]         tab_count, tab_count_next;
  logic [31:0]        field_accum [NUM_FIELDS];
  logic [31:0]        field_accum_next [NUM_FIELDS];
  field_phase_t       field_phase [NUM_FIELDS];
  field_phase_t       field_phase_next [NUM_FIELDS];
  logic               field_negative [NUM_FIELDS];
  logic               field_negative_next [NUM_FIELDS];

  // Result register
  logic       out_valid;
  out_item_t  out_word, out_word_next;
  logic       emit;

  logic       out_free;
  logic       proc;

  // Field accumulator path
  logic [7:0]  c;
  logic [31:0] acc_sel;
  logic [34:0] acc_prod;
  logic        is_digit;
  logic        is_space;
  logic        is_sign;

  assign out_free = !out_valid || result.ready;
  assign proc     = in_valid && out_free;
  assign rx.ready = !in_valid || proc;

  assign result.valid   = out_valid;
  assign result.payload = out_word;

  // Hold the accepted word until the parse stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      in_word <= rx.payload;
    end
  end

  // Classify the byte and form the next accumulator value
  always_comb begin
    c        = in_word.rx_byte;
    acc_sel  = field_accum[tab_count];
    is_digit = (c >= BYTE_ZERO) && (c <= BYTE_NINE);
    is_space = (c == BYTE_SP) || ((c >= BYTE_TAB) && (c <= BYTE_CR));
    is_sign  = (c == BYTE_PLUS) || (c == BYTE_MINUS);
    acc_prod = ({3'b000, acc_sel} << 3) + ({3'b000, acc_sel} << 1)
             + {31'd0, c[3:0]};
  end

  // Parser next state and result word
  always_comb begin
    in_frame_next    = in_frame;
    byte_count_next  = byte_count;
    second_byte_next = second_byte;
    tab_count_next   = tab_count;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      field_accum_next[i]    = field_accum[i];
      field_phase_next[i]    = field_phase[i];
      field_negative_next[i] = field_negative[i];
    end
    emit          = 1'b0;
    out_word_next = '0;

    if (proc) begin
      if (!in_frame) begin
        // Drop everything outside a frame except STX
        if (c == BYTE_STX) begin
          in_frame_next   = 1'b1;
          byte_count_next = CNT_ONE;
        end
      end else if (c != BYTE_ETX) begin
        if (byte_count == CNT_ONE) begin
          second_byte_next = c;
        end
        if (byte_count < CNT_MAX) begin
          byte_count_next = byte_count + CNT_ONE;
        end
        if ((c == BYTE_TAB) && (tab_count != 2'd3)) begin
          tab_count_next = tab_count + 2'd1;
        end else if (field_phase[tab_count] != PH_DONE) begin
          // Feed the current field, atoi style
          if (is_digit) begin
            field_accum_next[tab_count] = (acc_prod > {3'b000, MAG_CAP}) ?
                                          MAG_CAP : acc_prod[31:0];
            field_phase_next[tab_count] = PH_NUM;
          end else if ((field_phase[tab_count] == PH_SKIP) && is_space) begin
            field_phase_next[tab_count] = PH_SKIP;
          end else if ((field_phase[tab_count] == PH_SKIP) && is_sign) begin
            field_negative_next[tab_count] = (c == BYTE_MINUS);
            field_phase_next[tab_count]    = PH_NUM;
          end else begin
            field_phase_next[tab_count] = PH_DONE;
          end
        end
      end else begin
        // Close the frame and classify it
        emit = 1'b1;
        priority if (byte_count >= CNT_MAX) begin
          out_word_next.frame_kind     = KIND_FORMAT;
          out_word_next.request_done   = 1'b1;
          out_word_next.request_failed = 1'b1;
        end else if (second_byte == BYTE_ACK) begin
          out_word_next.frame_kind   = KIND_ACK;
          out_word_next.request_done = (in_word.pending_request != REQ_GET);
        end else if (second_byte == BYTE_NAK) begin
          out_word_next.frame_kind     = KIND_NAK;
          out_word_next.request_done   = 1'b1;
          out_word_next.request_failed = 1'b1;
        end else if (byte_count < CNT_SHORT) begin
          out_word_next.frame_kind     = KIND_FORMAT;
          out_word_next.request_done   = 1'b1;
          out_word_next.request_failed = 1'b1;
        end else if (tab_count != 2'd3) begin
          out_word_next.frame_kind     = KIND_MISSING;
          out_word_next.request_done   = 1'b1;
          out_word_next.request_failed = 1'b1;
        end else begin
          out_word_next.frame_kind     = KIND_DATA;
          out_word_next.request_done   = 1'b1;
          out_word_next.reply_ack      = 1'b1;
          out_word_next.command_code   = field_result(field_accum[0], field_negative[0]);
          out_word_next.property_code  = field_result(field_accum[1], field_negative[1]);
          out_word_next.property_value = field_result(field_accum[2], field_negative[2]);
          out_word_next.frame_check    = field_result(field_accum[3], field_negative[3]);
        end
        in_frame_next    = 1'b0;
        byte_count_next  = '0;
        second_byte_next = '0;
        tab_count_next   = '0;
        for (int i = 0; i < NUM_FIELDS; i++) begin
          field_accum_next[i]    = '0;
          field_phase_next[i]    = PH_SKIP;
          field_negative_next[i] = 1'b0;
        end
      end
    end
  end

  // Advance parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      byte_count  <= '0;
      second_byte <= '0;
      tab_count   <= '0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        field_accum[i]    <= '0;
        field_phase[i]    <= PH_SKIP;
        field_negative[i] <= 1'b0;
      end
    end else begin
      in_frame    <= in_frame_next;
      byte_count  <= byte_count_next;
      second_byte <= second_byte_next;
      tab_count   <= tab_count_next;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        field_accum[i]    <= field_accum_next[i];
        field_phase[i]    <= field_phase_next[i];
        field_negative[i] <= field_negative_next[i];
      end
    end
  end

  // Load or drain the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      out_word <= out_word_next;
    end
  end

  // A closing ETX always yields a result on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (proc && in_frame && (c == BYTE_ETX)) |=> (out_valid && !in_frame))
    else $error("closing ETX did not produce a result");

  // Only data results carry field values
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_word.frame_kind != KIND_DATA)) |->
    ((out_word.command_code == 32'd0) && (out_word.property_code == 32'd0) &&
     (out_word.property_value == 32'd0) && (out_word.frame_check == 32'd0)))
    else $error("non-data result carries field values");

  // An ACK reply is asked only for a successful data frame
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.reply_ack) |->
    ((out_word.frame_kind == KIND_DATA) && out_word.request_done &&
     !out_word.request_failed))
    else $error("reply_ack on a non-data result");

  // The byte count never passes capacity and is zero outside a frame
  assert property (@(posedge clk) disable iff (rst)
    (byte_count <= CNT_MAX) && (in_frame || (byte_count == '0)))
    else $error("byte count out of range");

  // A waiting result holds while not taken
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=> (out_valid && $stable(out_word)))
    else $error("result changed while stalled");

endmodule

// ----- tb/tab_field_frame_parser_tb.sv -----
// Testbench for tab_field_frame_parser: drives received bytes, predicts each
// classified frame and checks every result word. Depends on tffp_pkg,
// tffp_stream_if and the parser RTL.
`timescale 1ns / 1ps

module tab_field_frame_parser_tb;
  import tffp_pkg::*;

  localparam int unsigned FRAME_CAP = 64;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned RANDOM_BYTES = 1250;

  typedef struct {
    in_item_t word;
    bit       hurry;
    bit       drain_first;
  } rx_plan_t;

  logic clk;
  logic rst;

  tffp_stream_if #(.payload_t(in_item_t))  rx_if ();
  tffp_stream_if #(.payload_t(out_item_t)) res_if ();

  tab_field_frame_parser #(
    .MAX_FRAME_BYTES(FRAME_CAP)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .result (res_if)
  );

  // Bytes waiting to be offered, and classified frames waiting to come out
  rx_plan_t  rx_schedule[$];
  out_item_t awaited_frames[$];

  // Parser state as the testbench tracks it
  bit           frm_open;
  int unsigned  frm_len;
  logic [7:0]   frm_second;
  int unsigned  frm_tabs;
  logic [31:0]  fld_mag [NUM_FIELDS];
  field_phase_t fld_phase [NUM_FIELDS];
  bit           fld_neg [NUM_FIELDS];

  int       mismatches;
  int       results_seen;
  int       planned;
  bit       hurry_now;
  bit       drain_next;
  rx_plan_t next_word;
  int       rx_gap;
  int       stall_left;
  int       hold_left;
  int       idle_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic clear_frame();
    frm_open   = 1'b0;
    frm_len    = 0;
    frm_second = 8'h00;
    frm_tabs   = 0;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      fld_mag[k]   = 32'd0;
      fld_phase[k] = PH_SKIP;
      fld_neg[k]   = 1'b0;
    end
  endtask

  // Advance the tracked parser by one accepted byte; queue a frame on ETX
  task automatic track_rx_byte(input in_item_t w);
    out_item_t   r;
    logic [7:0]  c;
    logic [63:0] prod;
    logic [31:0] vals [NUM_FIELDS];
    int unsigned f;
    c = w.rx_byte;
    if (!frm_open) begin
      // outside a frame only STX matters
      if (c == BYTE_STX) begin
        clear_frame();
        frm_open = 1'b1;
        frm_len  = 1;
      end
    end else if (c != BYTE_ETX) begin
      if (frm_len == 1)
        frm_second = c;
      if (frm_len < FRAME_CAP)
        frm_len++;
      if (c == BYTE_TAB && frm_tabs < 3) begin
        frm_tabs++;
      end else begin
        // atoi-style parse of the current field
        f = frm_tabs;
        if (fld_phase[f] != PH_DONE) begin
          if (c >= BYTE_ZERO && c <= BYTE_NINE) begin
            prod = {32'd0, fld_mag[f]} * 64'd10 + {56'd0, c - BYTE_ZERO};
            fld_mag[f]   = (prod > {32'd0, MAG_CAP}) ? MAG_CAP : prod[31:0];
            fld_phase[f] = PH_NUM;
          end else if (fld_phase[f] == PH_SKIP &&
                       (c == BYTE_PLUS || c == BYTE_MINUS)) begin
            fld_neg[f]   = (c == BYTE_MINUS);
            fld_phase[f] = PH_NUM;
          end else if (!(fld_phase[f] == PH_SKIP &&
                         (c == BYTE_SP || (c >= BYTE_TAB && c <= BYTE_CR)))) begin
            fld_phase[f] = PH_DONE;
          end
        end
      end
    end else begin
      // classify the closed frame
      r = '0;
      if (frm_len >= FRAME_CAP) begin
        r.frame_kind     = KIND_FORMAT;
        r.request_done   = 1'b1;
        r.request_failed = 1'b1;
      end else if (frm_second == BYTE_ACK) begin
        r.frame_kind   = KIND_ACK;
        r.request_done = (w.pending_request != REQ_GET);
      end else if (frm_second == BYTE_NAK) begin
        r.frame_kind     = KIND_NAK;
        r.request_done   = 1'b1;
        r.request_failed = 1'b1;
      end else if (frm_len + 1 < MIN_FRAME_LEN) begin
        r.frame_kind     = KIND_FORMAT;
        r.request_done   = 1'b1;
        r.request_failed = 1'b1;
      end else if (frm_tabs < 3) begin
        r.frame_kind     = KIND_MISSING;
        r.request_done   = 1'b1;
        r.request_failed = 1'b1;
      end else begin
        for (int k = 0; k < NUM_FIELDS; k++) begin
          if (fld_neg[k])
            vals[k] = -fld_mag[k];
          else
            vals[k] = (fld_mag[k] > POS_MAX) ? POS_MAX : fld_mag[k];
        end
        r.frame_kind     = KIND_DATA;
        r.request_done   = 1'b1;
        r.reply_ack      = 1'b1;
        r.command_code   = vals[0];
        r.property_code  = vals[1];
        r.property_value = vals[2];
        r.frame_check    = vals[3];
      end
      awaited_frames = {awaited_frames, r};
      clear_frame();
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d",
               $time, name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // Stimulus helpers
  function automatic logic [1:0] rand_req();
    return 2'($urandom_range(0, 3));
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic [1:0] req);
    rx_plan_t p;
    p.word.rx_byte         = b;
    p.word.pending_request = req;
    p.hurry                = hurry_now;
    p.drain_first          = drain_next;
    drain_next             = 1'b0;
    rx_schedule = {rx_schedule, p};
    planned++;
  endtask

  function automatic logic [7:0] any_but_etx();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == BYTE_ETX) ? 8'h41 : b;
  endfunction

  // One decimal field: optional whitespace, optional sign, digits, junk
  task automatic add_field();
    int n;
    int k;
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 2);
      repeat (n) begin
        k = $urandom_range(0, 4);
        add_byte((k == 0) ? BYTE_SP : 8'(8'h09 + k), rand_req());
      end
    end
    k = $urandom_range(0, 3);
    if (k == 0)
      add_byte(BYTE_PLUS, rand_req());
    else if (k == 1)
      add_byte(BYTE_MINUS, rand_req());
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 4);
    repeat (n)
      add_byte(BYTE_ZERO + 8'($urandom_range(0, 9)), rand_req());
    if ($urandom_range(0, 5) == 0) begin
      b = any_but_etx();
      add_byte((b == BYTE_TAB) ? BYTE_SP : b, rand_req());
    end
  endtask

  // Stimulus plan, reset and end of run
  initial begin
    int pick;
    int n;
    int frame_no;
    rx_if.valid   = 1'b0;
    rx_if.payload = '0;
    res_if.ready  = 1'b0;
    rst           = 1'b1;
    mismatches    = 0;
    planned       = 0;
    hurry_now     = 1'b0;
    drain_next    = 1'b0;
    clear_frame();

    // noise outside a frame
    add_byte(8'hFF, REQ_RSVD);
    add_byte(BYTE_ETX, REQ_NONE);
    // immediate ETX: short frame
    add_byte(BYTE_STX, REQ_NONE);
    add_byte(BYTE_ETX, REQ_SET);
    // ACK while a get is pending: request stays open
    add_byte(BYTE_STX, REQ_NONE);
    add_byte(BYTE_ACK, REQ_NONE);
    add_byte(BYTE_ETX, REQ_GET);
    // NAK with the reserved request code
    add_byte(BYTE_STX, REQ_NONE);
    add_byte(BYTE_NAK, REQ_NONE);
    add_byte(BYTE_ETX, REQ_RSVD);
    // long enough, one tab only
    add_byte(BYTE_STX, REQ_NONE);
    add_byte(BYTE_ZERO + 8'd1, REQ_NONE);
    add_byte(BYTE_TAB, REQ_NONE);
    add_byte(BYTE_ZERO + 8'd2, REQ_NONE);
    add_byte(BYTE_STX, REQ_NONE);
    add_byte(BYTE_ZERO + 8'd4, REQ_NONE);
    add_byte(BYTE_ETX, REQ_SET);
    // data frame with a lone minus sign and an extra tab in the check field
    add_byte(BYTE_STX, REQ_NONE);
    add_byte(BYTE_MINUS, REQ_NONE);
    add_byte(BYTE_TAB, REQ_NONE);
    add_byte(BYTE_TAB, REQ_NONE);
    add_byte(BYTE_TAB, REQ_NONE);
    add_byte(BYTE_TAB, REQ_NONE);
    add_byte(BYTE_ZERO + 8'd7, REQ_NONE);
    add_byte(BYTE_ETX, REQ_NONE);

    // random frames, mostly well formed
    frame_no = 0;
    n = planned + RANDOM_BYTES;
    while (planned < n) begin
      frame_no++;
      hurry_now = ($urandom_range(0, 4) == 0);
      if (frame_no == 25 || $urandom_range(0, 29) == 0)
        drain_next = 1'b1;
      pick = $urandom_range(0, 19);
      if (pick <= 12) begin
        add_byte(BYTE_STX, rand_req());
        for (int f = 0; f < NUM_FIELDS; f++) begin
          add_field();
          if (f < NUM_FIELDS - 1)
            add_byte(BYTE_TAB, rand_req());
        end
        if ($urandom_range(0, 7) == 0)
          add_byte(BYTE_TAB, rand_req());
        add_byte(BYTE_ETX, rand_req());
      end else if (pick <= 14) begin
        add_byte(BYTE_STX, rand_req());
        add_byte((pick == 13) ? BYTE_ACK : BYTE_NAK, rand_req());
        repeat ($urandom_range(0, 8))
          add_byte(any_but_etx(), rand_req());
        add_byte(BYTE_ETX, rand_req());
      end else if (pick == 15) begin
        add_byte(BYTE_STX, rand_req());
        repeat ($urandom_range(0, 12))
          add_byte(($urandom_range(0, 2) == 0) ? BYTE_TAB : any_but_etx(),
                   rand_req());
        add_byte(BYTE_ETX, rand_req());
      end else if (pick == 16) begin
        // near or over capacity, sometimes posing as an ACK
        add_byte(BYTE_STX, rand_req());
        add_byte($urandom_range(0, 1) ? BYTE_ACK : any_but_etx(), rand_req());
        repeat ($urandom_range(60, 68))
          add_byte(any_but_etx(), rand_req());
        add_byte(BYTE_ETX, rand_req());
      end else if (pick == 17) begin
        repeat ($urandom_range(1, 6))
          add_byte(8'($urandom_range(0, 255)), rand_req());
      end else begin
        // frame cut short, no ETX
        add_byte(BYTE_STX, rand_req());
        add_field();
        add_byte(BYTE_TAB, rand_req());
        add_field();
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // wait for every word to go in, then for every frame to come out
    while (rx_schedule.size() > 0 || rx_if.valid)
      @(posedge clk);
    while (awaited_frames.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Driver: offer planned words with random gaps
  always @(posedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
      rx_gap = 0;
    end else begin
      if (rx_if.valid && rx_if.ready)
        track_rx_byte(rx_if.payload);
      if (!rx_if.valid || rx_if.ready) begin
        if (rx_gap > 0) begin
          rx_gap--;
          rx_if.valid <= 1'b0;
        end else if (rx_schedule.size() > 0 &&
                     !(rx_schedule[0].drain_first && awaited_frames.size() > 0)) begin
          next_word = rx_schedule[0];
          rx_schedule.delete(0);
          rx_if.valid   <= 1'b1;
          rx_if.payload <= next_word.word;
          rx_gap = next_word.hurry ? 0 : $urandom_range(0, 18);
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take results with random stalls and check each word
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_left   = 0;
      hold_left    = 0;
      results_seen = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (awaited_frames.size() == 0) begin
          $display("%0t: unexpected result word, kind %0d",
                   $time, res_if.payload.frame_kind);
          mismatches++;
        end else begin
          compare_field("frame_kind", 32'(awaited_frames[0].frame_kind),
                        32'(res_if.payload.frame_kind));
          compare_field("request_done", 32'(awaited_frames[0].request_done),
                        32'(res_if.payload.request_done));
          compare_field("request_failed", 32'(awaited_frames[0].request_failed),
                        32'(res_if.payload.request_failed));
          compare_field("reply_ack", 32'(awaited_frames[0].reply_ack),
                        32'(res_if.payload.reply_ack));
          compare_field("command_code", awaited_frames[0].command_code,
                        res_if.payload.command_code);
          compare_field("property_code", awaited_frames[0].property_code,
                        res_if.payload.property_code);
          compare_field("property_value", awaited_frames[0].property_value,
                        res_if.payload.property_value);
          compare_field("frame_check", awaited_frames[0].frame_check,
                        res_if.payload.frame_check);
          awaited_frames.delete(0);
        end
        results_seen++;
        // hold off long enough for the parser to back up into its input
        if (results_seen == 15)
          hold_left = 300;
        stall_left = (results_seen >= 40 && results_seen < 55) ? 0 : $urandom_range(0, 18);
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

// ----- tab_field_frame_parser.f -----
src/tffp_pkg.sv
src/tffp_stream_if.sv
src/tab_field_frame_parser.sv
tb/tab_field_frame_parser_tb.sv
